// ----- hw/rtl/lfd_pkg.sv -----
`default_nettype none

package lfd_pkg;

    localparam int MAX_FIELD_BYTES_DEF = 32;
    localparam int POS_W               = 6;
    localparam int LEN_W               = 32;
    localparam int BYTE_W              = 8;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTH_FORMAT   = 3'd0,
        REG_FIELD_BYTES     = 3'd1,
        REG_LEAD_SKIP       = 3'd2,
        REG_TRAIL_SKIP      = 3'd3,
        REG_HEADER_INCLUDED = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FMT_BIG     = 2'd0,
        FMT_LITTLE  = 2'd1,
        FMT_DECIMAL = 2'd2,
        FMT_NONE    = 2'd3
    } t_fmt;

    typedef struct packed {
        t_fmt        length_format;
        logic [5:0]  field_bytes;
        logic [3:0]  lead_skip;
        logic [3:0]  trail_skip;
        logic        header_included;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/lfd_byte_if.sv -----
`default_nettype none

interface lfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;

    modport source (output valid, output header_byte, input ready);
    modport sink   (input valid, input header_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lfd_len_if.sv -----
`default_nettype none

interface lfd_len_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] msg_length;

    modport source (output valid, output msg_length, input ready);
    modport sink   (input valid, input msg_length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lfd_cfg.sv -----
`default_nettype none

module lfd_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lfd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output lfd_pkg::t_cfg                         o_cfg
);
    import lfd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.length_format   <= FMT_BIG;
            r_cfg.field_bytes     <= 6'd4;
            r_cfg.lead_skip       <= 4'd0;
            r_cfg.trail_skip      <= 4'd0;
            r_cfg.header_included <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_LENGTH_FORMAT:   r_cfg.length_format   <= t_fmt'(i_cfg_data[1:0]);
                REG_FIELD_BYTES:     r_cfg.field_bytes     <= i_cfg_data[5:0];
                REG_LEAD_SKIP:       r_cfg.lead_skip       <= i_cfg_data[3:0];
                REG_TRAIL_SKIP:      r_cfg.trail_skip      <= i_cfg_data[3:0];
                REG_HEADER_INCLUDED: r_cfg.header_included <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hw/rtl/lfd_core.sv -----
`default_nettype none

module lfd_core #(
    parameter int MAX_FIELD_BYTES = lfd_pkg::MAX_FIELD_BYTES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  lfd_pkg::t_cfg i_cfg,
    lfd_byte_if.sink      in_byte,
    lfd_len_if.source     out_len
);
    import lfd_pkg::*;

    localparam logic [1:0] PH_BLANK  = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    logic                    r_in_valid;
    logic [BYTE_W-1:0]       r_in_byte;
    logic [POS_W-1:0]        r_pos;
    logic [LEN_W-1:0]        r_acc;
    logic [1:0]              r_phase;
    logic                    r_neg;
    logic                    r_out_valid;
    logic [LEN_W-1:0]        r_out_len;

    logic [LEN_W-1:0]        n_acc;
    logic [1:0]              n_phase;
    logic                    n_neg;
    logic [LEN_W-1:0]        n_result;

    logic                    advance;
    logic                    emit;
    logic                    in_field;
    logic                    is_digit;
    logic                    is_blank;
    logic [5:0]              fb;
    logic [6:0]              pos7;
    logic [6:0]              lead7;
    logic [6:0]              end7;
    logic [6:0]              total7;
    logic [6:0]              k7;
    logic [LEN_W-1:0]        digit_val;

    assign advance       = !r_out_valid || out_len.ready;
    assign in_byte.ready = !r_in_valid || advance;

    always_comb begin
        if (i_cfg.field_bytes == 6'd0) begin
            fb = 6'd1;
        end else if (i_cfg.field_bytes > 6'(MAX_FIELD_BYTES)) begin
            fb = 6'(MAX_FIELD_BYTES);
        end else begin
            fb = i_cfg.field_bytes;
        end
    end

    assign pos7      = {1'b0, r_pos};
    assign lead7     = {3'b000, i_cfg.lead_skip};
    assign end7      = lead7 + {1'b0, fb};
    assign total7    = end7 + {3'b000, i_cfg.trail_skip};
    assign k7        = pos7 - lead7;
    assign in_field  = (pos7 >= lead7) && (pos7 < end7);
    assign emit      = (pos7 + 7'd1) >= total7;
    assign is_digit  = (r_in_byte >= 8'h30) && (r_in_byte <= 8'h39);
    assign is_blank  = (r_in_byte == 8'h20) || ((r_in_byte >= 8'h09) && (r_in_byte <= 8'h0D));
    assign digit_val = {28'd0, r_in_byte[3:0]};

    always_comb begin
        n_acc   = r_acc;
        n_phase = r_phase;
        n_neg   = r_neg;
        if (in_field) begin
            case (i_cfg.length_format)
                FMT_BIG: begin
                    n_acc = {r_acc[LEN_W-9:0], r_in_byte};
                end
                FMT_LITTLE: begin
                    if (k7 < 7'd4) begin
                        n_acc = r_acc | ({24'd0, r_in_byte} << {k7[1:0], 3'b000});
                    end
                end
                FMT_DECIMAL: begin
                    if (r_phase == PH_BLANK) begin
                        if (is_blank) begin
                            n_phase = PH_BLANK;
                        end else if (r_in_byte == 8'h2B) begin
                            n_phase = PH_DIGITS;
                        end else if (r_in_byte == 8'h2D) begin
                            n_neg   = 1'b1;
                            n_phase = PH_DIGITS;
                        end else if (is_digit) begin
                            n_acc   = digit_val;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end else if (r_phase == PH_DIGITS) begin
                        if (is_digit) begin
                            n_acc = (r_acc << 3) + (r_acc << 1) + digit_val;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (i_cfg.length_format == FMT_NONE) begin
            n_result = '0;
        end else if ((i_cfg.length_format == FMT_DECIMAL) && n_neg) begin
            n_result = '0 - n_acc;
        end else begin
            n_result = n_acc;
        end
        if (!i_cfg.header_included) begin
            n_result = n_result + {25'd0, total7};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_phase     <= PH_BLANK;
            r_neg       <= 1'b0;
        end else begin
            if (in_byte.ready) begin
                r_in_valid <= in_byte.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && emit;
                if (r_in_valid) begin
                    if (emit) begin
                        r_pos   <= '0;
                        r_acc   <= '0;
                        r_phase <= PH_BLANK;
                        r_neg   <= 1'b0;
                    end else begin
                        r_pos   <= r_pos + 6'd1;
                        r_acc   <= n_acc;
                        r_phase <= n_phase;
                        r_neg   <= n_neg;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_byte.ready && in_byte.valid) begin
            r_in_byte <= in_byte.header_byte;
        end
        if (advance && r_in_valid && emit) begin
            r_out_len <= n_result;
        end
    end

    assign out_len.valid      = r_out_valid;
    assign out_len.msg_length = r_out_len;

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && emit) |=> (r_pos == '0 && r_acc == '0 && !r_neg))
        else $error("header state not cleared after a result");

    a_phase_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_UNUSED)
        else $error("decimal phase reached an unused code");

    a_sign_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_neg |-> (r_phase != PH_BLANK))
        else $error("sign recorded while still skipping blanks");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("buffered byte lost while output stalled");

endmodule

`default_nettype wire

// ----- hw/rtl/length_field_decoder_unit.sv -----
// Length field decoder.
// Header bytes arrive on in_byte, one transaction per byte. Each header is
// lead_skip ignored bytes, a length field of field_bytes bytes (big endian,
// little endian, ASCII decimal or none) and trail_skip ignored bytes. On
// the last byte of a header one transaction with the decoded length leaves
// on out_len; other bytes produce no output transaction.
// The user must write the configuration registers (i_cfg_we, i_cfg_idx,
// i_cfg_data) only while no header is in flight; the block does not check.
// Throughput is one byte per cycle while out_len is not stalled. Each byte
// passes an input register and one pass of shift or multiply-by-ten logic
// into the accumulator, and for the last header byte into the result
// register that drives out_len, written only when out_len is not stalled.
// Reset (synchronous, active low) loads the register defaults and clears
// the header position and accumulator.
// When the receiver stalls, the result register holds and one more byte is
// buffered in the input register; further bytes then see ready low.
`default_nettype none

module length_field_decoder_unit #(
    parameter int MAX_FIELD_BYTES = lfd_pkg::MAX_FIELD_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lfd_byte_if.sink                            in_byte,
    lfd_len_if.source                           out_len
);
    import lfd_pkg::*;

    t_cfg cfg;

    lfd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lfd_core #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .in_byte (in_byte),
        .out_len (out_len)
    );

endmodule

`default_nettype wire

// ----- tb/lfd_length_checker.sv -----
`timescale 1ns / 100ps

module lfd_length_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lfd_byte_if                                 byte_ch,
    lfd_len_if                                  len_ch,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import lfd_pkg::*;

    typedef enum logic [1:0] {
        DEC_BLANKS = 2'd0,
        DEC_DIGITS = 2'd1,
        DEC_DONE   = 2'd2
    } t_dec_phase;

    t_fmt        fmt_r;
    logic [5:0]  field_bytes_r;
    logic [3:0]  lead_skip_r;
    logic [3:0]  trail_skip_r;
    logic        header_included_r;

    logic [5:0]  byte_pos;
    logic [31:0] length_acc;
    t_dec_phase  dec_phase;
    logic        dec_negative;

    logic [31:0] pending_lengths [$];
    logic [31:0] want_len;
    int          fail_count;
    int          checked;

    function automatic int field_span(input logic [5:0] fb);
        if (fb == 6'd0) begin
            return 1;
        end
        if (fb > MAX_FIELD_BYTES_DEF) begin
            return MAX_FIELD_BYTES_DEF;
        end
        return int'(fb);
    endfunction

    task automatic clear_header();
        byte_pos     = '0;
        length_acc   = '0;
        dec_phase    = DEC_BLANKS;
        dec_negative = 1'b0;
    endtask

    task automatic decode_header_byte(input logic [7:0] c);
        int          span;
        int          total;
        int          pos;
        int          k;
        logic        is_digit;
        logic        is_blank;
        logic [31:0] msg_len;
        span     = field_span(field_bytes_r);
        total    = int'(lead_skip_r) + span + int'(trail_skip_r);
        pos      = int'(byte_pos);
        is_digit = (c >= "0") && (c <= "9");
        is_blank = (c == " ") || ((c >= "\t") && (c <= "\r"));
        if (pos >= int'(lead_skip_r) && pos < int'(lead_skip_r) + span) begin
            k = pos - int'(lead_skip_r);
            case (fmt_r)
                FMT_BIG: begin
                    length_acc = {length_acc[23:0], c};
                end
                FMT_LITTLE: begin
                    if (k < 4) begin
                        length_acc = length_acc | (32'(c) << (8 * k));
                    end
                end
                FMT_DECIMAL: begin
                    if (dec_phase == DEC_BLANKS) begin
                        if (!is_blank) begin
                            if (c == "+") begin
                                dec_phase = DEC_DIGITS;
                            end else if (c == "-") begin
                                dec_negative = 1'b1;
                                dec_phase    = DEC_DIGITS;
                            end else if (is_digit) begin
                                length_acc = 32'(c - "0");
                                dec_phase  = DEC_DIGITS;
                            end else begin
                                dec_phase = DEC_DONE;
                            end
                        end
                    end else if (dec_phase == DEC_DIGITS) begin
                        if (is_digit) begin
                            length_acc = length_acc * 32'd10 + 32'(c - "0");
                        end else begin
                            dec_phase = DEC_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (pos + 1 < total) begin
            byte_pos = byte_pos + 6'd1;
        end else begin
            if (fmt_r == FMT_NONE) begin
                msg_len = '0;
            end else if (fmt_r == FMT_DECIMAL && dec_negative) begin
                msg_len = 32'd0 - length_acc;
            end else begin
                msg_len = length_acc;
            end
            if (!header_included_r) begin
                msg_len = msg_len + 32'(total);
            end
            pending_lengths.push_back(msg_len);
            clear_header();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_r             = FMT_BIG;
            field_bytes_r     = 6'd4;
            lead_skip_r       = '0;
            trail_skip_r      = '0;
            header_included_r = 1'b1;
            clear_header();
            pending_lengths.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            if (len_ch.valid && len_ch.ready) begin
                if (pending_lengths.size() == 0) begin
                    $display("%0t: msg_length expected none, actual %0d", $time,
                             $signed(len_ch.msg_length));
                    fail_count++;
                end else begin
                    want_len = pending_lengths.pop_front();
                    checked++;
                    if (len_ch.msg_length !== want_len) begin
                        $display("%0t: msg_length expected %0d, actual %0d", $time,
                                 $signed(want_len), $signed(len_ch.msg_length));
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LENGTH_FORMAT:   fmt_r             = t_fmt'(i_cfg_data[1:0]);
                    REG_FIELD_BYTES:     field_bytes_r     = i_cfg_data[5:0];
                    REG_LEAD_SKIP:       lead_skip_r       = i_cfg_data[3:0];
                    REG_TRAIL_SKIP:      trail_skip_r      = i_cfg_data[3:0];
                    REG_HEADER_INCLUDED: header_included_r = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (byte_ch.valid && byte_ch.ready) begin
                decode_header_byte(byte_ch.header_byte);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_lengths.size();
        o_checked    <= checked;
    end

endmodule

// ----- tb/tb_length_field_decoder_unit.sv -----
`timescale 1ns / 100ps

module tb_length_field_decoder_unit;
    import lfd_pkg::*;

    localparam int                   CYCLE_LIMIT  = 200000;
    localparam int                   RANDOM_BYTES = 1750;
    localparam int                   DRAIN_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lfd_byte_if byte_ch ();
    lfd_len_if  len_ch ();

    int fail_count;
    int pending;
    int checked;

    int tx_idle_pct;
    int rx_idle_pct;
    int cycle_count;
    int bytes_sent;
    int settings_used;
    int random_start;
    int progress;
    int phase;
    int header_cnt;

    t_fmt       cfg_fmt;
    logic [5:0] cfg_field_bytes;
    logic [3:0] cfg_lead;
    logic [3:0] cfg_trail;
    t_fmt       pick_fmt;
    logic [5:0] pick_fb;
    logic [3:0] pick_lead;
    logic [3:0] pick_trail;

    length_field_decoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_byte    (byte_ch),
        .out_len    (len_ch)
    );

    lfd_length_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .byte_ch      (byte_ch),
        .len_ch       (len_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        len_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d lengths outstanding.",
                     cycle_count, pending);
            $display("length_field_decoder_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] blank_char();
        if ($urandom_range(5) == 0) begin
            return " ";
        end
        return 8'("\t" + $urandom_range(4));
    endfunction

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.header_byte <= value;
        @(posedge i_clk);
        while (!byte_ch.ready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Unused data bits of the narrow registers carry random values.
    task automatic configure(input t_fmt fmt, input logic [5:0] fb, input logic [3:0] lead,
                             input logic [3:0] trail, input logic incl);
        cfg_fmt         = fmt;
        cfg_field_bytes = fb;
        cfg_lead        = lead;
        cfg_trail       = trail;
        if ($urandom_range(3) == 0) begin
            write_reg(REG_UNUSED, 6'($urandom));
        end
        write_reg(REG_LENGTH_FORMAT, {4'($urandom), fmt});
        write_reg(REG_FIELD_BYTES, fb);
        write_reg(REG_LEAD_SKIP, {2'($urandom), lead});
        write_reg(REG_TRAIL_SKIP, {2'($urandom), trail});
        write_reg(REG_HEADER_INCLUDED, {5'($urandom), incl});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Decimal fields are mostly well formed: blanks, an optional sign, digits
    // and sometimes a NUL, with random bytes filling the rest of the field.
    task automatic send_header();
        logic [7:0] field [$];
        int         span;
        if (cfg_field_bytes == 6'd0) begin
            span = 1;
        end else if (cfg_field_bytes > MAX_FIELD_BYTES_DEF) begin
            span = MAX_FIELD_BYTES_DEF;
        end else begin
            span = int'(cfg_field_bytes);
        end
        if (cfg_fmt == FMT_DECIMAL && $urandom_range(4) != 0) begin
            repeat ($urandom_range(2)) field.push_back(blank_char());
            case ($urandom_range(2))
                0: field.push_back("+");
                1: field.push_back("-");
                default: begin
                end
            endcase
            repeat ($urandom_range(1, 11)) field.push_back(8'("0" + $urandom_range(9)));
            if ($urandom_range(1) == 0) begin
                field.push_back(8'h00);
            end
        end
        while (field.size() < span) begin
            field.push_back(rand_byte());
        end
        repeat (cfg_lead) send_byte(rand_byte());
        for (int i = 0; i < span; i++) begin
            send_byte(field[i]);
        end
        repeat (cfg_trail) send_byte(rand_byte());
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= REG_LENGTH_FORMAT;
        i_cfg_data          <= '0;
        byte_ch.valid       <= 1'b0;
        byte_ch.header_byte <= '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        bytes_sent    = 0;
        settings_used = 0;
        cfg_fmt         = FMT_BIG;
        cfg_field_bytes = 6'd4;
        cfg_lead        = '0;
        cfg_trail       = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults after reset: four-byte big-endian field.
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        wait_idle();

        // Little endian keeps only the first four field bytes.
        configure(FMT_LITTLE, 6'd5, 4'd1, 4'd1, 1'b0);
        send_byte(8'hA5);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h04);
        send_byte(8'h55);
        send_byte(8'h5A);
        wait_idle();

        // Decimal with a blank, a minus sign and a NUL ending the number.
        configure(FMT_DECIMAL, 6'd6, 4'd0, 4'd0, 1'b1);
        send_byte("\t");
        send_byte("-");
        send_byte("4");
        send_byte("2");
        send_byte(8'h00);
        send_byte("9");
        wait_idle();

        // A zero field size counts as one byte; the invalid format yields zero.
        configure(FMT_NONE, 6'd0, 4'd0, 4'd0, 1'b0);
        send_byte(8'h7E);
        wait_idle();

        // A decimal field without digits decodes to zero.
        configure(FMT_DECIMAL, 6'd2, 4'd0, 4'd0, 1'b1);
        send_byte("x");
        send_byte("5");

        random_start = bytes_sent;
        phase        = 0;
        while (bytes_sent < random_start + RANDOM_BYTES) begin
            progress = bytes_sent - random_start;
            if (progress < RANDOM_BYTES / 3) begin
                tx_idle_pct = 27;
                rx_idle_pct = 73;
            end else if (progress < 2 * RANDOM_BYTES / 3) begin
                tx_idle_pct = 73;
                rx_idle_pct = 27;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wait_idle();
            pick_fmt = t_fmt'(2'($urandom_range(3)));
            if ($urandom_range(2) == 0) begin
                pick_fmt = FMT_DECIMAL;
            end
            case ($urandom_range(11))
                0: pick_fb = 6'd0;
                1: pick_fb = 6'($urandom_range(32, 63));
                2: pick_fb = 6'($urandom_range(9, 31));
                default: pick_fb = 6'($urandom_range(1, 8));
            endcase
            pick_lead  = ($urandom_range(7) == 0) ? 4'd15 : 4'($urandom_range(3));
            pick_trail = ($urandom_range(7) == 0) ? 4'd15 : 4'($urandom_range(3));
            if (phase == 0) begin
                pick_fb    = 6'd63;
                pick_lead  = 4'd15;
                pick_trail = 4'd15;
            end
            configure(pick_fmt, pick_fb, pick_lead, pick_trail, 1'($urandom));
            if (pick_fb > 6'd8 || pick_lead == 4'd15 || pick_trail == 4'd15) begin
                header_cnt = $urandom_range(1, 2);
            end else begin
                header_cnt = $urandom_range(3, 10);
            end
            repeat (header_cnt) send_header();
            phase++;
        end
        wait_idle();

        $display("Sent %0d header bytes under %0d register settings; %0d lengths compared.",
                 bytes_sent, settings_used, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("length_field_decoder_unit: match");
        end else begin
            $display("length_field_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
